// ===== rtl/bcomp_pkg.sv =====
package bcomp_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int PRESS_W = 32;
    localparam int TEMP_W  = 19;

    // APB register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int NREG   = 6;

    localparam logic [2:0] REG_CAL_SENS          = 3'd0;
    localparam logic [2:0] REG_CAL_OFFSET        = 3'd1;
    localparam logic [2:0] REG_CAL_SENS_TEMPCO   = 3'd2;
    localparam logic [2:0] REG_CAL_OFFSET_TEMPCO = 3'd3;
    localparam logic [2:0] REG_CAL_REF_TEMP      = 3'd4;
    localparam logic [2:0] REG_CAL_TEMP_COEFF    = 3'd5;

    // Number of register stages from accept to result
    localparam int NSTAGE = 9;

    // Temperature breakpoints relative to the first-order temperature term
    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] COLD_DIST = 19'sd3500;

    // Calibration words
    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_coeff;
    } t_cal;

    // Per-stage load enables
    typedef logic [NSTAGE-1:0] t_stage_en;

    // Hand-off from the temperature half to the pressure half
    typedef struct packed {
        logic [RAW_W-1:0]  d1;
        logic [34:0]       oterm;
        logic [33:0]       sterm;
        logic [39:0]       off2;
        logic [39:0]       sens2;
        logic [TEMP_W-1:0] tout;
    } t_mid;

endpackage

// ===== rtl/bcomp_if.sv =====
interface bcomp_in_if;
    import bcomp_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bcomp_out_if;
    import bcomp_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRESS_W-1:0] pressure_out;
    logic [TEMP_W-1:0]  temperature_out;

    modport source (output valid, output pressure_out, output temperature_out, input ready);
    modport sink   (input valid, input pressure_out, input temperature_out, output ready);
endinterface

// ===== rtl/bcomp_apb_regs.sv =====
module bcomp_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcomp_pkg::ADDR_W-1:0] paddr,
    input  logic [bcomp_pkg::DATA_W-1:0] pwdata,
    output logic [bcomp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output bcomp_pkg::t_cal             o_cal
);
    import bcomp_pkg::*;

    t_cal       r_cal;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cal  = r_cal;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CAL_SENS:          r_cal.sens          <= pwdata[CAL_W-1:0];
                REG_CAL_OFFSET:        r_cal.offset        <= pwdata[CAL_W-1:0];
                REG_CAL_SENS_TEMPCO:   r_cal.sens_tempco   <= pwdata[CAL_W-1:0];
                REG_CAL_OFFSET_TEMPCO: r_cal.offset_tempco <= pwdata[CAL_W-1:0];
                REG_CAL_REF_TEMP:      r_cal.ref_temp      <= pwdata[CAL_W-1:0];
                REG_CAL_TEMP_COEFF:    r_cal.temp_coeff    <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_CAL_SENS:          prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.sens};
            REG_CAL_OFFSET:        prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.offset};
            REG_CAL_SENS_TEMPCO:   prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.sens_tempco};
            REG_CAL_OFFSET_TEMPCO: prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.offset_tempco};
            REG_CAL_REF_TEMP:      prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.ref_temp};
            REG_CAL_TEMP_COEFF:    prdata = {{(DATA_W-CAL_W){1'b0}}, r_cal.temp_coeff};
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== rtl/bcomp_pipe_ctrl.sv =====
module bcomp_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output bcomp_pkg::t_stage_en o_en
);
    import bcomp_pkg::*;

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE-1:0] n_v;
    logic [NSTAGE:0]   w_chain;

    // A stage loads when it is empty or its successor moves on
    always_comb begin
        w_chain[NSTAGE] = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_chain[k] = !r_v[k] || w_chain[k+1];
        end
    end

    assign n_v         = {r_v[NSTAGE-2:0], i_in_valid};
    assign o_en        = w_chain[NSTAGE-1:0];
    assign o_in_ready  = w_chain[0];
    assign o_out_valid = r_v[NSTAGE-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (w_chain[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

endmodule

// ===== rtl/bcomp_temp_path.sv =====
module bcomp_temp_path (
    input  logic                        i_clk,
    input  bcomp_pkg::t_stage_en        i_en,
    input  bcomp_pkg::t_cal             i_cal,
    input  logic [bcomp_pkg::RAW_W-1:0] i_raw_pressure,
    input  logic [bcomp_pkg::RAW_W-1:0] i_raw_temperature,
    output bcomp_pkg::t_mid             o_mid
);
    import bcomp_pkg::*;

    // Stage 0: dT
    logic [RAW_W-1:0]    r_d1_0;
    logic signed [24:0]  r_dt;
    logic signed [24:0]  n_dt;

    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.ref_temp, 8'h00});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d1_0 <= i_raw_pressure;
            r_dt   <= n_dt;
        end
    end

    // Stage 1: the four products of dT
    logic [RAW_W-1:0]    r_d1_1;
    logic signed [41:0]  r_mt, r_mo, r_ms, n_mt, n_mo, n_ms;
    logic signed [49:0]  r_mdd, n_mdd;

    assign n_mt  = r_dt * $signed({1'b0, i_cal.temp_coeff});
    assign n_mo  = r_dt * $signed({1'b0, i_cal.offset_tempco});
    assign n_ms  = r_dt * $signed({1'b0, i_cal.sens_tempco});
    assign n_mdd = r_dt * r_dt;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_d1_1 <= r_d1_0;
            r_mt   <= n_mt;
            r_mo   <= n_mo;
            r_ms   <= n_ms;
            r_mdd  <= n_mdd;
        end
    end

    // Stage 2: a = TEMP - 2000, b = TEMP + 1500, T2, scaled tempco terms
    logic [RAW_W-1:0]          r_d1_2;
    logic signed [TEMP_W-1:0]  r_a, r_b, n_a, n_b;
    logic [17:0]               r_t2;
    logic [34:0]               r_oterm_2;
    logic [33:0]               r_sterm_2;

    assign n_a = r_mt[41:23];
    assign n_b = n_a + COLD_DIST;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_d1_2    <= r_d1_1;
            r_a       <= n_a;
            r_b       <= n_b;
            r_t2      <= r_mdd[48:31];
            r_oterm_2 <= r_mo[41:7];
            r_sterm_2 <= r_ms[41:8];
        end
    end

    // Stage 3: squares and the temperature result
    logic [RAW_W-1:0]         r_d1_3;
    logic [35:0]              r_aa, r_bb;
    logic signed [37:0]       n_aa, n_bb;
    logic                     r_lo, r_vlo;
    logic signed [TEMP_W-1:0] r_tout_3, n_tout;
    logic signed [TEMP_W-1:0] w_t2_sel;
    logic [34:0]              r_oterm_3;
    logic [33:0]              r_sterm_3;

    assign n_aa     = r_a * r_a;
    assign n_bb     = r_b * r_b;
    assign w_t2_sel = r_a[TEMP_W-1] ? $signed({1'b0, r_t2}) : '0;
    assign n_tout   = r_a + TEMP_BASE - w_t2_sel;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_d1_3    <= r_d1_2;
            r_aa      <= n_aa[35:0];
            r_bb      <= n_bb[35:0];
            r_lo      <= r_a[TEMP_W-1];
            r_vlo     <= r_b[TEMP_W-1];
            r_tout_3  <= n_tout;
            r_oterm_3 <= r_oterm_2;
            r_sterm_3 <= r_sterm_2;
        end
    end

    // Stage 4: second-order offset and sensitivity corrections
    logic [39:0] w_aa5, w_bb7, w_bb11, n_off2, n_sens2;
    t_mid        r_mid;

    assign w_aa5  = ({4'b0, r_aa} << 2) + {4'b0, r_aa};
    assign w_bb7  = ({4'b0, r_bb} << 3) - {4'b0, r_bb};
    assign w_bb11 = ({4'b0, r_bb} << 3) + ({4'b0, r_bb} << 1) + {4'b0, r_bb};

    always_comb begin
        n_off2  = '0;
        n_sens2 = '0;
        if (r_lo) begin
            n_off2  = (w_aa5 >> 1) + (r_vlo ? w_bb7 : '0);
            n_sens2 = (w_aa5 >> 2) + (r_vlo ? (w_bb11 >> 1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_mid.d1    <= r_d1_3;
            r_mid.oterm <= r_oterm_3;
            r_mid.sterm <= r_sterm_3;
            r_mid.off2  <= n_off2;
            r_mid.sens2 <= n_sens2;
            r_mid.tout  <= r_tout_3;
        end
    end

    assign o_mid = r_mid;

endmodule

// ===== rtl/bcomp_press_path.sv =====
module bcomp_press_path (
    input  logic                          i_clk,
    input  bcomp_pkg::t_stage_en          i_en,
    input  bcomp_pkg::t_cal               i_cal,
    input  bcomp_pkg::t_mid               i_mid,
    output logic [bcomp_pkg::PRESS_W-1:0] o_pressure,
    output logic [bcomp_pkg::TEMP_W-1:0]  o_temperature
);
    import bcomp_pkg::*;

    // Stage 5: OFF and SENS
    logic [RAW_W-1:0]    r_d1_5;
    logic signed [41:0]  r_off_5, r_sens, n_off, n_sens;
    logic [TEMP_W-1:0]   r_tout_5;

    assign n_off  = $signed({10'b0, i_cal.offset, 16'h0000}) + $signed(i_mid.oterm)
                  - $signed({2'b0, i_mid.off2});
    assign n_sens = $signed({11'b0, i_cal.sens, 15'h0000}) + $signed(i_mid.sterm)
                  - $signed({2'b0, i_mid.sens2});

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_d1_5   <= i_mid.d1;
            r_off_5  <= n_off;
            r_sens   <= n_sens;
            r_tout_5 <= i_mid.tout;
        end
    end

    // Stage 6: D1 * SENS as two partial products
    logic [44:0]         r_pp_lo, n_pp_lo;
    logic signed [45:0]  r_pp_hi, n_pp_hi;
    logic signed [41:0]  r_off_6;
    logic [TEMP_W-1:0]   r_tout_6;

    assign n_pp_lo = r_d1_5 * r_sens[20:0];
    assign n_pp_hi = $signed({1'b0, r_d1_5}) * $signed(r_sens[41:21]);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_pp_lo  <= n_pp_lo;
            r_pp_hi  <= n_pp_hi;
            r_off_6  <= r_off_5;
            r_tout_6 <= r_tout_5;
        end
    end

    // Stage 7: recombine; the full product fits in 64 bits
    logic [63:0]         r_prod, n_prod;
    logic signed [41:0]  r_off_7;
    logic [TEMP_W-1:0]   r_tout_7;

    assign n_prod = {r_pp_hi[42:0], 21'h0} + {19'b0, r_pp_lo};

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_prod   <= n_prod;
            r_off_7  <= r_off_6;
            r_tout_7 <= r_tout_6;
        end
    end

    // Stage 8: P = ((prod >>> 21) - OFF) >>> 15
    logic signed [43:0]  n_diff;
    logic [PRESS_W-1:0]  r_p;
    logic [TEMP_W-1:0]   r_tout_8;

    assign n_diff = $signed(r_prod[63:21]) - r_off_7;

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_p      <= {{3{n_diff[43]}}, n_diff[43:15]};
            r_tout_8 <= r_tout_7;
        end
    end

    assign o_pressure    = r_p;
    assign o_temperature = r_tout_8;

endmodule

// ===== rtl/barometric_pressure_compensation.sv =====
// A result passes registered stages 0 to 8 after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the
// nine-stage pipeline has a multiplier stage for the dT products, the
// squares and the D1*SENS split. A stalled output holds its stage;
// bubbles upstream still fill. Reset (i_rst_n low, synchronous) clears
// the pipeline valid bits and all calibration registers to zero.
module barometric_pressure_compensation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bcomp_in_if.sink                     i_req,
    bcomp_out_if.source                  o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcomp_pkg::ADDR_W-1:0] paddr,
    input  logic [bcomp_pkg::DATA_W-1:0] pwdata,
    output logic [bcomp_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import bcomp_pkg::*;

    t_cal      w_cal;
    t_stage_en w_en;
    t_mid      w_mid;

    // Calibration registers
    bcomp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (w_cal)
    );

    // Valid bits and stage enables
    bcomp_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .o_en        (w_en)
    );

    // Temperature and correction terms, stages 0 to 4
    bcomp_temp_path u_temp (
        .i_clk             (i_clk),
        .i_en              (w_en),
        .i_cal             (w_cal),
        .i_raw_pressure    (i_req.raw_pressure),
        .i_raw_temperature (i_req.raw_temperature),
        .o_mid             (w_mid)
    );

    // Pressure, stages 5 to 8
    bcomp_press_path u_press (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_cal         (w_cal),
        .i_mid         (w_mid),
        .o_pressure    (o_res.pressure_out),
        .o_temperature (o_res.temperature_out)
    );

endmodule

// ===== rtl/bcomp_checker.sv =====
module bcomp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bcomp_pkg::PRESS_W-1:0] i_pressure,
    input logic [bcomp_pkg::TEMP_W-1:0]  i_temperature
);
    import bcomp_pkg::*;

    logic [4:0] r_cnt;
    logic       w_acc, w_del;

    assign w_acc = i_in_valid && i_in_ready;
    assign w_del = i_out_valid && i_out_ready;

    // Requests in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {4'b0, w_acc} - {4'b0, w_del};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pressure) && $stable(i_temperature))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with an empty output stage");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 5'd0)
        else $error("result shown with no request in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'(NSTAGE))
        else $error("more requests in flight than pipeline stages");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind barometric_pressure_compensation bcomp_checker u_bcomp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_pressure    (o_res.pressure_out),
    .i_temperature (o_res.temperature_out)
);
